@@ rtl/tlsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsr_pkg
// Shared types, constants and helper functions of the tape loop slot resolver.
// ----------------------------------------------------------------------------
package tlsr_pkg;

    localparam int SLOTS  = 64;
    localparam int TAG_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PASS_W = $clog2(2 * SLOTS + 1);
    localparam int IDX_W  = TAG_W + 2;
    localparam int POS_W  = 48;
    localparam int SPAN_W = 32;
    localparam int THR_W  = 15;
    localparam int DIV_W  = 48;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam logic [THR_W-1:0] THR_RESET = 15'd256;

    typedef enum logic [1:0] {
        OP_RECORD  = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_ERASE   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_CHK,
        S_DIVA,
        S_DIVB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SPAN_W-1:0] start;
        logic [SPAN_W-1:0] span;
    } t_slot;

    function automatic logic [SPAN_W-1:0] sat32(input logic signed [49:0] v);
        logic [SPAN_W-1:0] r;
        if (v > 50'sh0_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -50'sh0_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] old_index(input logic [TAG_W-1:0] n,
                                                   input logic [CNT_W-1:0] f);
        logic [IDX_W-1:0] s;
        s = IDX_W'(n) + IDX_W'(1) + IDX_W'(SLOTS) - IDX_W'(f);
        if (s >= IDX_W'(SLOTS)) begin
            s = s - IDX_W'(SLOTS);
        end
        if (s >= IDX_W'(SLOTS)) begin
            s = s - IDX_W'(SLOTS);
        end
        return s[TAG_W-1:0];
    endfunction

endpackage

@@ rtl/tlsr_cell.sv @@
// ----------------------------------------------------------------------------
// tlsr_cell
// One slot of the rotating ring: holds a tagged slot and passes it on.
// ----------------------------------------------------------------------------
module tlsr_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [tlsr_pkg::TAG_W-1:0] i_tag_init,
    input  logic                i_clear,
    input  logic                i_shift,
    input  tlsr_pkg::t_slot     i_prev,
    output tlsr_pkg::t_slot     o_slot
);

    tlsr_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.tag   <= i_tag_init;
            r_slot.start <= '0;
            r_slot.span  <= '0;
        end else if (i_clear) begin
            r_slot.start <= '0;
            r_slot.span  <= '0;
        end else if (i_shift) begin
            r_slot <= i_prev;
        end
    end

    assign o_slot = r_slot;

endmodule

@@ rtl/tlsr_divider.sv @@
// ----------------------------------------------------------------------------
// tlsr_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlsr_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tlsr_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tlsr_pkg::SPAN_W-1:0] i_divisor,
    output logic [tlsr_pkg::DIV_W-1:0]  o_quotient,
    output logic                        o_done
);

    logic                         r_busy;
    logic                         r_done;
    logic [tlsr_pkg::DCNT_W-1:0]  r_cnt;
    logic [tlsr_pkg::SPAN_W-1:0]  r_rem;
    logic [tlsr_pkg::SPAN_W-1:0]  r_div;
    logic [tlsr_pkg::DIV_W-1:0]   r_quo;
    logic [tlsr_pkg::SPAN_W:0]    w_trial;
    logic                         w_ge;

    assign w_trial = {r_rem, r_quo[tlsr_pkg::DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tlsr_pkg::DCNT_W'(tlsr_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= tlsr_pkg::SPAN_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[tlsr_pkg::SPAN_W-1:0];
            end
            r_quo <= {r_quo[tlsr_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

@@ rtl/tape_loop_slot_resolver.sv @@
// ----------------------------------------------------------------------------
// tape_loop_slot_resolver
// Ring of recorded tape passes with record, resolve and erase commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; operation, position
// and read_span are sampled then. Each command gives one result, shown for a
// single cycle with o_valid high; the receiver cannot hold it off.
// The slots sit in a ring of cells that rotates by one cell every cycle while
// a command makes its pass, and all slot work happens at the last cell as the
// ring goes by, but for erase, which clears every cell when it is taken.
// Record, erase and the unused code make one full turn of the ring. Resolve
// makes two full turns, since the walk may begin anywhere in the first turn;
// a hit adds two divisions in the shared divider.
// The threshold register is written through i_cfg_valid and o_cfg_ready,
// which is high while the block is idle.
// Reset empties the ring, clears head and origin and sets the threshold to
// 256; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module tape_loop_slot_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [47:0] i_position,
    input  logic [31:0] i_read_span,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data,
    output logic        o_valid,
    output logic [5:0]  o_slot_index,
    output logic        o_found,
    output logic [16:0] o_phase,
    output logic [31:0] o_stretch,
    output logic [47:0] o_oldest_position
);

    localparam int TW = tlsr_pkg::TAG_W;
    localparam int CW = tlsr_pkg::CNT_W;
    localparam int PW = tlsr_pkg::PASS_W;

    tlsr_pkg::t_state r_state, n_state;
    tlsr_pkg::t_op    r_op;
    tlsr_pkg::t_slot  w_cell [tlsr_pkg::SLOTS];
    tlsr_pkg::t_slot  w_head, w_fb;

    logic [tlsr_pkg::THR_W-1:0] r_thr;
    logic [47:0]      r_head, r_origin, r_shift;
    logic [TW-1:0]    r_newest, r_wslot, r_old_idx, r_fslot;
    logic [CW-1:0]    r_filled, r_walk;
    logic [PW-1:0]    r_cnt;
    logic [31:0]      r_new_start, r_new_span, r_old_start, r_rspan, r_fsp;
    logic             r_rebase, r_started, r_found;
    logic signed [49:0] r_local, r_diff;
    logic [16:0]      r_phase;
    logic [31:0]      r_stretch;
    logic             r_o_valid, r_o_found;
    logic [5:0]       r_o_slot;
    logic [16:0]      r_o_phase;
    logic [31:0]      r_o_stretch;
    logic [47:0]      r_o_oldest;

    logic             w_accept, w_shift, w_clear, w_last, w_active, w_match;
    logic [47:0]      w_newhead, w_adv, w_run;
    logic [31:0]      w_span_rec;
    logic [TW-1:0]    w_wslot, w_newest_rs;
    logic [CW-1:0]    w_filled_rec;
    logic signed [49:0] w_st_ext, w_fb_ext, w_oldv;
    logic             w_div_start, w_div_done;
    logic [47:0]      w_dividend, w_quot;

    assign w_accept    = start && (r_state == tlsr_pkg::S_IDLE);
    assign busy        = (r_state != tlsr_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == tlsr_pkg::S_IDLE);
    assign w_shift     = (r_state == tlsr_pkg::S_PASS);
    assign w_clear     = w_accept && (tlsr_pkg::t_op'(i_operation) == tlsr_pkg::OP_ERASE);

    for (genvar k = 0; k < tlsr_pkg::SLOTS; k++) begin : g_ring
        tlsr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tag_init (TW'(k)),
            .i_clear    (w_clear),
            .i_shift    (w_shift),
            .i_prev     ((k == 0) ? w_fb : w_cell[(k == 0) ? 0 : k - 1]),
            .o_slot     (w_cell[k])
        );
    end

    assign w_head = w_cell[tlsr_pkg::SLOTS-1];

    always_comb begin
        w_newhead    = (i_position > r_head) ? i_position : r_head;
        w_adv        = w_newhead - r_head;
        w_run        = w_newhead - r_origin;
        if (w_adv == '0) begin
            w_span_rec = 32'd1;
        end else if (w_adv[47:32] != '0) begin
            w_span_rec = 32'hFFFF_FFFF;
        end else begin
            w_span_rec = w_adv[31:0];
        end
        w_wslot      = (r_newest == TW'(tlsr_pkg::SLOTS - 1)) ? '0 : r_newest + 1'b1;
        w_filled_rec = (r_filled == CW'(tlsr_pkg::SLOTS)) ? r_filled : r_filled + 1'b1;
        w_newest_rs  = r_newest;
    end

    always_comb begin
        w_fb = w_head;
        if (r_op == tlsr_pkg::OP_RECORD && w_head.tag == r_wslot) begin
            w_fb.start = r_new_start;
            w_fb.span  = r_new_span;
        end
        w_fb_ext = {{18{w_fb.start[31]}}, w_fb.start};
        if (r_rebase && w_fb.span != '0) begin
            w_fb.start = tlsr_pkg::sat32(w_fb_ext - $signed({2'b00, r_shift}));
        end
        w_st_ext = {{18{w_head.start[31]}}, w_head.start};
        w_match  = (w_head.span != '0) && (r_local >= w_st_ext);
        w_active = (r_op == tlsr_pkg::OP_RESOLVE) && (r_rspan != '0)
                   && (r_started || w_head.tag == r_newest)
                   && (r_walk < r_filled) && !r_found;
        w_last   = (r_op == tlsr_pkg::OP_RESOLVE) ? (r_cnt == PW'(2 * tlsr_pkg::SLOTS - 1))
                                                  : (r_cnt == PW'(tlsr_pkg::SLOTS - 1));
        w_oldv   = $signed({2'b00, r_origin}) + $signed({{18{r_old_start[31]}}, r_old_start});
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_dividend  = {r_diff[31:0], 16'b0};
        unique case (r_state)
            tlsr_pkg::S_IDLE: begin
                if (start) begin
                    n_state = tlsr_pkg::S_PASS;
                end
            end
            tlsr_pkg::S_PASS: begin
                if (w_last) begin
                    n_state = tlsr_pkg::S_CHK;
                end
            end
            tlsr_pkg::S_CHK: begin
                if (r_found) begin
                    w_div_start = 1'b1;
                    n_state     = tlsr_pkg::S_DIVA;
                end else begin
                    n_state = tlsr_pkg::S_DONE;
                end
            end
            tlsr_pkg::S_DIVA: begin
                w_dividend = {r_rspan, 16'b0};
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    n_state     = tlsr_pkg::S_DIVB;
                end
            end
            tlsr_pkg::S_DIVB: begin
                if (w_div_done) begin
                    n_state = tlsr_pkg::S_DONE;
                end
            end
            tlsr_pkg::S_DONE: begin
                n_state = tlsr_pkg::S_IDLE;
            end
            default: begin
                n_state = tlsr_pkg::S_IDLE;
            end
        endcase
    end

    tlsr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_fsp),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tlsr_pkg::S_IDLE;
            r_thr     <= tlsr_pkg::THR_RESET;
            r_head    <= '0;
            r_origin  <= '0;
            r_newest  <= TW'(tlsr_pkg::SLOTS - 1);
            r_filled  <= '0;
            r_o_valid <= 1'b0;
            r_op      <= tlsr_pkg::OP_NONE;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_started <= 1'b0;
            r_walk    <= '0;
            r_rebase  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (w_accept) begin
                r_op      <= tlsr_pkg::t_op'(i_operation);
                r_cnt     <= '0;
                r_found   <= 1'b0;
                r_started <= 1'b0;
                r_walk    <= '0;
                r_rebase  <= 1'b0;
                r_old_idx <= tlsr_pkg::old_index(w_newest_rs, r_filled);
                case (tlsr_pkg::t_op'(i_operation))
                    tlsr_pkg::OP_RECORD: begin
                        r_head      <= w_newhead;
                        r_newest    <= w_wslot;
                        r_wslot     <= w_wslot;
                        r_filled    <= w_filled_rec;
                        r_new_span  <= w_span_rec;
                        r_new_start <= tlsr_pkg::sat32($signed({2'b00, r_head})
                                                       - $signed({2'b00, r_origin}));
                        r_old_idx   <= tlsr_pkg::old_index(w_wslot, w_filled_rec);
                        r_shift     <= w_run;
                        if (w_run > {17'b0, r_thr, 16'b0}) begin
                            r_rebase <= 1'b1;
                            r_origin <= w_newhead;
                        end
                    end
                    tlsr_pkg::OP_ERASE: begin
                        r_head   <= '0;
                        r_origin <= '0;
                        r_newest <= TW'(tlsr_pkg::SLOTS - 1);
                        r_filled <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == tlsr_pkg::S_PASS) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_active) begin
                    r_started <= 1'b1;
                    r_walk    <= r_walk + 1'b1;
                    if (w_match) begin
                        r_found <= 1'b1;
                    end
                end
            end
            if (r_state == tlsr_pkg::S_DONE) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rspan <= i_read_span;
            r_local <= $signed({2'b00, i_position}) - $signed({2'b00, r_origin});
        end
        if (r_state == tlsr_pkg::S_PASS) begin
            if (w_fb.tag == r_old_idx) begin
                r_old_start <= w_fb.start;
            end
            if (w_active && w_match) begin
                r_fslot <= w_head.tag;
                r_fsp   <= w_head.span;
                r_diff  <= r_local - w_st_ext;
            end
        end
        if (r_state == tlsr_pkg::S_DIVA && w_div_done) begin
            if (r_diff >= $signed({18'b0, r_fsp})) begin
                r_phase <= 17'h1_0000;
            end else begin
                r_phase <= w_quot[16:0];
            end
        end
        if (r_state == tlsr_pkg::S_DIVB && w_div_done) begin
            r_stretch <= (w_quot[47:32] != '0) ? 32'hFFFF_FFFF : w_quot[31:0];
        end
        if (r_state == tlsr_pkg::S_DONE) begin
            r_o_found   <= 1'b0;
            r_o_phase   <= '0;
            r_o_stretch <= '0;
            r_o_slot    <= '0;
            if (r_op == tlsr_pkg::OP_RECORD) begin
                r_o_slot <= 6'(r_wslot);
            end else if (r_op == tlsr_pkg::OP_RESOLVE && r_found) begin
                r_o_slot    <= 6'(r_fslot);
                r_o_found   <= 1'b1;
                r_o_phase   <= r_phase;
                r_o_stretch <= r_stretch;
            end
            if (r_filled == '0) begin
                r_o_oldest <= r_head;
            end else if (w_oldv < 0) begin
                r_o_oldest <= '0;
            end else if (w_oldv[49:48] != 2'b00) begin
                r_o_oldest <= 48'hFFFF_FFFF_FFFF;
            end else begin
                r_o_oldest <= w_oldv[47:0];
            end
        end
    end

    assign o_valid           = r_o_valid;
    assign o_slot_index      = r_o_slot;
    assign o_found           = r_o_found;
    assign o_phase           = r_o_phase;
    assign o_stretch         = r_o_stretch;
    assign o_oldest_position = r_o_oldest;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a transaction is still running");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_phase <= 17'h1_0000)
        else $error("phase above one");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(tlsr_pkg::SLOTS))
        else $error("fill count above ring size");

endmodule
